[rtl/idf48_pkg.sv]
// constants and types for the double to 48-bit legacy float converter
// no dependencies
`timescale 1ns / 1ps
package idf48_pkg;
    localparam logic [47:0] SAT_POS  = 48'hFEFFFFFFFFFF;
    localparam logic [47:0] SAT_NEG  = 48'hFF0000000000;
    localparam logic [47:0] ZERO_WRD = 48'h800000000000;
    localparam logic [41:0] NEG_BASE = 42'h20000000000;
    localparam logic [40:0] MANT_ONE = 41'h10000000000;

    // special handling decided in stage one
    typedef enum logic [2:0] {
        K_NORM = 3'b001,
        K_FIX  = 3'b010,
        K_ZERO = 3'b100
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        neg;
        logic [47:0] fixed;
        logic [52:0] sig;
        logic [12:0] exponent;
        logic [5:0]  lz;
    } t_s1;
endpackage

[rtl/idf48_norm.sv]
// stage one: classify the input and count leading zeros of subnormal fractions
// depends on idf48_pkg
`timescale 1ns / 1ps
module idf48_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [63:0]      i_ieee_bits,
    output idf48_pkg::t_s1   o_s1
);
    import idf48_pkg::*;

    t_s1         n_s1;
    t_s1         r_s1;
    logic [10:0] efield;
    logic [51:0] frac;
    logic [5:0]  lz;

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (frac[i]) begin
                lz = 6'(51 - i);
            end
        end
    end

    always_comb begin
        efield         = i_ieee_bits[62:52];
        frac           = i_ieee_bits[51:0];
        // valid is cleared while reset is held
        n_s1.valid     = i_valid & i_rst_n;
        n_s1.neg       = i_ieee_bits[63];
        n_s1.kind      = K_NORM;
        n_s1.fixed     = SAT_POS;
        n_s1.lz        = 6'd0;
        n_s1.sig       = {1'b1, frac};
        n_s1.exponent  = 13'({2'b00, efield}) - 13'd1022;
        if (efield == 11'h7FF) begin
            n_s1.kind  = K_FIX;
            n_s1.fixed = (frac == 52'd0 && i_ieee_bits[63]) ? SAT_NEG : SAT_POS;
        end else if (efield == 11'd0) begin
            if (frac == 52'd0) begin
                n_s1.kind  = K_FIX;
                n_s1.fixed = ZERO_WRD;
            end else begin
                // leading one at 51-lz, exponent = p - 1073
                n_s1.sig      = {1'b0, frac};
                n_s1.lz       = lz + 6'd1;
                n_s1.exponent = 13'd51 - 13'({7'd0, lz}) - 13'd1073;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1 = r_s1;
endmodule

[rtl/ieee_double_to_48bit_float_core.sv]
// top level of the double to 48-bit legacy float converter
// depends on idf48_pkg and idf48_norm
`timescale 1ns / 1ps
// Converts one IEEE-754 double per clock into a 48-bit legacy float word
// (exponent biased by 64, two's-complement mantissa). Fully pipelined in
// four register stages: classify and count zeros, shift, round, pack, and
// a transaction passes through all four before it shows on o_valid; busy
// is never raised and results cannot be held off by the receiver.
module ieee_double_to_48bit_float_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_ieee_bits,
    output logic        o_valid,
    output logic [47:0] o_legacy_word
);
    import idf48_pkg::*;

    t_s1         s1;
    t_s1         n_s2;
    t_s1         r_s2;
    logic        r_v3;
    t_kind       r_k3;
    logic        r_neg3;
    logic [47:0] r_fix3;
    logic [40:0] r_w3;
    logic [12:0] r_e3;
    logic [47:0] n_out;
    logic [12:0] e4;
    logic [41:0] mag;
    logic        r_v4;
    logic [47:0] r_out;

    assign busy = 1'b0;

    idf48_norm u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start),
        .i_ieee_bits (i_ieee_bits),
        .o_s1        (s1)
    );

    // stage two: normalizing shift
    always_comb begin
        n_s2       = s1;
        n_s2.sig   = s1.sig << s1.lz;
        n_s2.valid = s1.valid & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    // stage three: round half up, renormalize on carry
    always_ff @(posedge i_clk) begin
        r_k3   <= r_s2.kind;
        r_neg3 <= r_s2.neg;
        r_fix3 <= r_s2.fixed;
        if ((41'(r_s2.sig[52:13]) + 41'(r_s2.sig[12])) >= MANT_ONE) begin
            r_w3 <= MANT_ONE >> 1;
            r_e3 <= r_s2.exponent + 13'd1;
        end else begin
            r_w3 <= 41'(r_s2.sig[52:13]) + 41'(r_s2.sig[12]);
            r_e3 <= r_s2.exponent;
        end
        r_v3 <= i_rst_n & r_s2.valid;
    end

    // stage four: range check and pack
    always_comb begin
        e4  = r_e3 + 13'd64;
        mag = r_neg3 ? (NEG_BASE - {1'b0, r_w3}) : {1'b0, r_w3};
        if (r_k3 != K_NORM) begin
            n_out = r_fix3;
        end else if ($signed(r_e3) < -13'sd64) begin
            n_out = 48'd0;
        end else if ($signed(r_e3) > 13'sd63) begin
            n_out = r_neg3 ? SAT_NEG : SAT_POS;
        end else begin
            n_out = {e4[6:0], mag[40:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_v4  <= i_rst_n & r_v3;
    end

    assign o_valid       = r_v4;
    assign o_legacy_word = r_out;
endmodule
